### rtl/core/rvid_pkg.sv
// Package for the RV32I instruction decoder: opcodes, operation and format codes, result struct.
`timescale 1ns / 1ps

package rvid_pkg;

    localparam int WORD_W = 32;
    localparam int REG_W  = 5;
    localparam int OP_W   = 6;
    localparam int FMT_W  = 3;

    localparam logic [6:0] OPC_OP     = 7'd51;
    localparam logic [6:0] OPC_OP_IMM = 7'd19;
    localparam logic [6:0] OPC_STORE  = 7'd35;
    localparam logic [6:0] OPC_LOAD   = 7'd3;
    localparam logic [6:0] OPC_BRANCH = 7'd99;
    localparam logic [6:0] OPC_JALR   = 7'd103;
    localparam logic [6:0] OPC_JAL    = 7'd111;
    localparam logic [6:0] OPC_AUIPC  = 7'd23;
    localparam logic [6:0] OPC_LUI    = 7'd55;

    localparam logic [6:0] F7_BASE = 7'd0;
    localparam logic [6:0] F7_ALT  = 7'd32;

    localparam logic [2:0] F3_0 = 3'd0;
    localparam logic [2:0] F3_1 = 3'd1;
    localparam logic [2:0] F3_2 = 3'd2;
    localparam logic [2:0] F3_3 = 3'd3;
    localparam logic [2:0] F3_4 = 3'd4;
    localparam logic [2:0] F3_5 = 3'd5;
    localparam logic [2:0] F3_6 = 3'd6;
    localparam logic [2:0] F3_7 = 3'd7;

    typedef enum logic [OP_W-1:0] {
        OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA, OP_OR, OP_AND,
        OP_ADDI, OP_SLLI, OP_SLTI, OP_SLTIU, OP_XORI, OP_SRLI, OP_SRAI, OP_ORI, OP_ANDI,
        OP_SB, OP_SH, OP_SW, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU,
        OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU,
        OP_JALR, OP_JAL, OP_AUIPC, OP_LUI
    } t_op;

    typedef enum logic [FMT_W-1:0] {
        FMT_R, FMT_I, FMT_S, FMT_B, FMT_U, FMT_J
    } t_fmt;

    typedef struct packed {
        logic               illegal;
        logic [OP_W-1:0]    operation;
        logic [FMT_W-1:0]   format;
        logic [REG_W-1:0]   dest_reg;
        logic [REG_W-1:0]   src1_reg;
        logic [REG_W-1:0]   src2_reg;
        logic [REG_W-1:0]   shift_amount;
        logic [WORD_W-1:0]  immediate;
    } t_dec;

endpackage

### rtl/core/rvid_decode.sv
// Combinational decode of one RV32I instruction word into its result fields.
`timescale 1ns / 1ps

module rvid_decode (
    input  logic [rvid_pkg::WORD_W-1:0] i_word,
    output rvid_pkg::t_dec              o_dec
);

    logic [6:0]                   opc;
    logic [2:0]                   f3;
    logic [6:0]                   f7;
    logic                         bad;
    rvid_pkg::t_op                op;
    rvid_pkg::t_fmt               fmt;
    logic                         use_rd;
    logic                         use_rs1;
    logic                         use_rs2;
    logic                         use_sh;
    logic [rvid_pkg::WORD_W-1:0]  imm;
    logic [rvid_pkg::WORD_W-1:0]  imm_i;
    logic [rvid_pkg::WORD_W-1:0]  imm_s;
    logic [rvid_pkg::WORD_W-1:0]  imm_b;
    logic [rvid_pkg::WORD_W-1:0]  imm_j;
    logic [rvid_pkg::WORD_W-1:0]  imm_u;
    logic                         f7_base;
    logic                         f7_alt;

    assign opc     = i_word[6:0];
    assign f3      = i_word[14:12];
    assign f7      = i_word[31:25];
    assign f7_base = (f7 == rvid_pkg::F7_BASE);
    assign f7_alt  = (f7 == rvid_pkg::F7_ALT);

    assign imm_i = {{20{i_word[31]}}, i_word[31:20]};
    assign imm_s = {{20{i_word[31]}}, i_word[31:25], i_word[11:7]};
    assign imm_b = {{19{i_word[31]}}, i_word[31], i_word[7], i_word[30:25],
                    i_word[11:8], 1'b0};
    assign imm_j = {{11{i_word[31]}}, i_word[31], i_word[19:12], i_word[20],
                    i_word[30:21], 1'b0};
    assign imm_u = {i_word[31:12], 12'd0};

    always_comb begin
        bad     = 1'b0;
        op      = rvid_pkg::OP_ADD;
        fmt     = rvid_pkg::FMT_R;
        use_rd  = 1'b0;
        use_rs1 = 1'b0;
        use_rs2 = 1'b0;
        use_sh  = 1'b0;
        imm     = '0;
        case (opc)
            rvid_pkg::OPC_OP: begin
                fmt     = rvid_pkg::FMT_R;
                use_rd  = 1'b1;
                use_rs1 = 1'b1;
                use_rs2 = 1'b1;
                case (f3)
                    rvid_pkg::F3_0: begin
                        op  = f7_alt ? rvid_pkg::OP_SUB : rvid_pkg::OP_ADD;
                        bad = !(f7_base || f7_alt);
                    end
                    rvid_pkg::F3_1: op = rvid_pkg::OP_SLL;
                    rvid_pkg::F3_2: op = rvid_pkg::OP_SLT;
                    rvid_pkg::F3_3: op = rvid_pkg::OP_SLTU;
                    rvid_pkg::F3_4: op = rvid_pkg::OP_XOR;
                    rvid_pkg::F3_5: begin
                        op  = f7_alt ? rvid_pkg::OP_SRA : rvid_pkg::OP_SRL;
                        bad = !(f7_base || f7_alt);
                    end
                    rvid_pkg::F3_6: op = rvid_pkg::OP_OR;
                    default:        op = rvid_pkg::OP_AND;
                endcase
            end
            rvid_pkg::OPC_OP_IMM: begin
                fmt     = rvid_pkg::FMT_I;
                use_rd  = 1'b1;
                use_rs1 = 1'b1;
                imm     = imm_i;
                case (f3)
                    rvid_pkg::F3_0: op = rvid_pkg::OP_ADDI;
                    rvid_pkg::F3_1: begin
                        op     = rvid_pkg::OP_SLLI;
                        use_sh = 1'b1;
                    end
                    rvid_pkg::F3_2: op = rvid_pkg::OP_SLTI;
                    rvid_pkg::F3_3: op = rvid_pkg::OP_SLTIU;
                    rvid_pkg::F3_4: op = rvid_pkg::OP_XORI;
                    rvid_pkg::F3_5: begin
                        op     = f7_alt ? rvid_pkg::OP_SRAI : rvid_pkg::OP_SRLI;
                        bad    = !(f7_base || f7_alt);
                        use_sh = 1'b1;
                    end
                    rvid_pkg::F3_6: op = rvid_pkg::OP_ORI;
                    default:        op = rvid_pkg::OP_ANDI;
                endcase
            end
            rvid_pkg::OPC_STORE: begin
                fmt     = rvid_pkg::FMT_S;
                use_rs1 = 1'b1;
                use_rs2 = 1'b1;
                imm     = imm_s;
                case (f3)
                    rvid_pkg::F3_0: op = rvid_pkg::OP_SB;
                    rvid_pkg::F3_1: op = rvid_pkg::OP_SH;
                    rvid_pkg::F3_2: op = rvid_pkg::OP_SW;
                    default:        bad = 1'b1;
                endcase
            end
            rvid_pkg::OPC_LOAD: begin
                fmt     = rvid_pkg::FMT_I;
                use_rd  = 1'b1;
                use_rs1 = 1'b1;
                imm     = imm_i;
                case (f3)
                    rvid_pkg::F3_0: op = rvid_pkg::OP_LB;
                    rvid_pkg::F3_1: op = rvid_pkg::OP_LH;
                    rvid_pkg::F3_2: op = rvid_pkg::OP_LW;
                    rvid_pkg::F3_4: op = rvid_pkg::OP_LBU;
                    rvid_pkg::F3_5: op = rvid_pkg::OP_LHU;
                    default:        bad = 1'b1;
                endcase
            end
            rvid_pkg::OPC_BRANCH: begin
                fmt     = rvid_pkg::FMT_B;
                use_rs1 = 1'b1;
                use_rs2 = 1'b1;
                imm     = imm_b;
                case (f3)
                    rvid_pkg::F3_0: op = rvid_pkg::OP_BEQ;
                    rvid_pkg::F3_1: op = rvid_pkg::OP_BNE;
                    rvid_pkg::F3_4: op = rvid_pkg::OP_BLT;
                    rvid_pkg::F3_5: op = rvid_pkg::OP_BGE;
                    rvid_pkg::F3_6: op = rvid_pkg::OP_BLTU;
                    rvid_pkg::F3_7: op = rvid_pkg::OP_BGEU;
                    default:        bad = 1'b1;
                endcase
            end
            rvid_pkg::OPC_JALR: begin
                fmt     = rvid_pkg::FMT_I;
                use_rd  = 1'b1;
                use_rs1 = 1'b1;
                imm     = imm_i;
                op      = rvid_pkg::OP_JALR;
                bad     = (f3 != rvid_pkg::F3_0);
            end
            rvid_pkg::OPC_JAL: begin
                fmt    = rvid_pkg::FMT_J;
                use_rd = 1'b1;
                imm    = imm_j;
                op     = rvid_pkg::OP_JAL;
            end
            rvid_pkg::OPC_AUIPC: begin
                fmt    = rvid_pkg::FMT_U;
                use_rd = 1'b1;
                imm    = imm_u;
                op     = rvid_pkg::OP_AUIPC;
            end
            rvid_pkg::OPC_LUI: begin
                fmt    = rvid_pkg::FMT_U;
                use_rd = 1'b1;
                imm    = imm_u;
                op     = rvid_pkg::OP_LUI;
            end
            default: bad = 1'b1;
        endcase
    end

    // illegal word: flag set, every other field zero
    always_comb begin
        o_dec = '0;
        if (bad) begin
            o_dec.illegal = 1'b1;
        end else begin
            o_dec.operation    = op;
            o_dec.format       = fmt;
            o_dec.dest_reg     = use_rd  ? i_word[11:7]  : '0;
            o_dec.src1_reg     = use_rs1 ? i_word[19:15] : '0;
            o_dec.src2_reg     = use_rs2 ? i_word[24:20] : '0;
            o_dec.shift_amount = use_sh  ? i_word[24:20] : '0;
            o_dec.immediate    = imm;
        end
    end

endmodule

### rtl/core/rv32i_instruction_decoder_unit.sv
// Top level of the RV32I instruction decoder: input register, decode, result register.
`timescale 1ns / 1ps

// RV32I decoder. A word is taken at every clock edge with start high and busy low;
// busy is low whenever reset is released, so one word per cycle is sustained. The
// word is registered in r_word, decoded by short combinational logic and the result
// registered in r_res, with o_done high for a single cycle as r_res is loaded;
// results in order. The receiver cannot stall: each result is shown once.

module rv32i_instruction_decoder_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [rvid_pkg::WORD_W-1:0]        i_instr_word,
    output logic                               o_done,
    output logic                               o_illegal,
    output logic [rvid_pkg::OP_W-1:0]          o_operation,
    output logic [rvid_pkg::FMT_W-1:0]         o_format,
    output logic [rvid_pkg::REG_W-1:0]         o_dest_reg,
    output logic [rvid_pkg::REG_W-1:0]         o_src1_reg,
    output logic [rvid_pkg::REG_W-1:0]         o_src2_reg,
    output logic [rvid_pkg::REG_W-1:0]         o_shift_amount,
    output logic signed [rvid_pkg::WORD_W-1:0] o_immediate
);

    logic                        r_vld;
    logic                        n_vld;
    logic [rvid_pkg::WORD_W-1:0] r_word;
    logic                        r_done;
    logic                        n_done;
    rvid_pkg::t_dec              r_res;
    rvid_pkg::t_dec              dec;

    assign busy   = ~i_rst_n;
    assign n_vld  = start & ~busy;
    assign n_done = r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= n_vld;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_vld) begin
            r_word <= i_instr_word;
        end
        if (r_vld) begin
            r_res <= dec;
        end
    end

    rvid_decode u_decode (
        .i_word (r_word),
        .o_dec  (dec)
    );

    assign o_done         = r_done;
    assign o_illegal      = r_res.illegal;
    assign o_operation    = r_res.operation;
    assign o_format       = r_res.format;
    assign o_dest_reg     = r_res.dest_reg;
    assign o_src1_reg     = r_res.src1_reg;
    assign o_src2_reg     = r_res.src2_reg;
    assign o_shift_amount = r_res.shift_amount;
    assign o_immediate    = $signed(r_res.immediate);

endmodule

### rtl/core/rvid_checker.sv
// Port-level checker for the RV32I decoder, bound to the top level.
`timescale 1ns / 1ps

module rvid_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               o_done,
    input logic                               o_illegal,
    input logic [rvid_pkg::OP_W-1:0]          o_operation,
    input logic [rvid_pkg::FMT_W-1:0]         o_format,
    input logic [rvid_pkg::REG_W-1:0]         o_dest_reg,
    input logic [rvid_pkg::REG_W-1:0]         o_src1_reg,
    input logic [rvid_pkg::REG_W-1:0]         o_src2_reg,
    input logic [rvid_pkg::REG_W-1:0]         o_shift_amount,
    input logic signed [rvid_pkg::WORD_W-1:0] o_immediate
);

    a_word_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("accepted word produced no result");

    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2))
        else $error("result without accepted word");

    a_illegal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_illegal) |-> (o_operation == '0 && o_format == '0 &&
            o_dest_reg == '0 && o_src1_reg == '0 && o_src2_reg == '0 &&
            o_shift_amount == '0 && o_immediate == '0))
        else $error("illegal result with nonzero fields");

    a_shift_only_imm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_shift_amount != '0) |-> (o_format == rvid_pkg::FMT_I &&
            o_src2_reg == '0 && o_immediate[4:0] == o_shift_amount))
        else $error("shift amount on non-shift result");

endmodule

bind rv32i_instruction_decoder_unit rvid_checker u_rvid_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_done         (o_done),
    .o_illegal      (o_illegal),
    .o_operation    (o_operation),
    .o_format       (o_format),
    .o_dest_reg     (o_dest_reg),
    .o_src1_reg     (o_src1_reg),
    .o_src2_reg     (o_src2_reg),
    .o_shift_amount (o_shift_amount),
    .o_immediate    (o_immediate)
);

### tb/tb_top.sv
// Testbench for the RV32I instruction decoder: directed table plus random words against a predictor.
`timescale 1ns / 1ps

module tb_top;
    import rvid_pkg::*;

    localparam int N_RANDOM    = 1025;
    localparam int N_STEADY    = 150;
    localparam int STALL_LIMIT = 1000;
    localparam int N_OPS       = int'(OP_LUI) + 1;

    localparam logic [6:0] VALID_OPC [0:8] = '{OPC_OP, OPC_OP_IMM, OPC_STORE, OPC_LOAD,
                                               OPC_BRANCH, OPC_JALR, OPC_JAL, OPC_AUIPC,
                                               OPC_LUI};

    typedef struct {
        logic [WORD_W-1:0] word;
        bit                typed;
        t_dec              want;
    } t_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [WORD_W-1:0]        i_instr_word;
    logic                     o_done;
    logic                     o_illegal;
    logic [OP_W-1:0]          o_operation;
    logic [FMT_W-1:0]         o_format;
    logic [REG_W-1:0]         o_dest_reg;
    logic [REG_W-1:0]         o_src1_reg;
    logic [REG_W-1:0]         o_src2_reg;
    logic [REG_W-1:0]         o_shift_amount;
    logic signed [WORD_W-1:0] o_immediate;

    t_dec decoded_q[$];
    t_row rows[$];
    int   errors;
    int   stall_cycles;
    int   words_decoded;
    int   illegal_count;
    bit   gaps_on;
    bit   op_seen [N_OPS];

    rv32i_instruction_decoder_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_instr_word   (i_instr_word),
        .o_done         (o_done),
        .o_illegal      (o_illegal),
        .o_operation    (o_operation),
        .o_format       (o_format),
        .o_dest_reg     (o_dest_reg),
        .o_src1_reg     (o_src1_reg),
        .o_src2_reg     (o_src2_reg),
        .o_shift_amount (o_shift_amount),
        .o_immediate    (o_immediate)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit f7_ok(input logic [6:0] f7);
        return (f7 == F7_BASE) || (f7 == F7_ALT);
    endfunction

    // Decoded fields expected for one instruction word.
    function automatic t_dec decode_word(input logic [WORD_W-1:0] w);
        t_dec        d;
        logic [6:0]  f7;
        logic [2:0]  f3;
        logic [31:0] imm_i;
        bit          bad;
        d     = '0;
        bad   = 1'b0;
        f7    = w[31:25];
        f3    = w[14:12];
        imm_i = {{20{w[31]}}, w[31:20]};
        d.dest_reg = w[11:7];
        d.src1_reg = w[19:15];
        d.src2_reg = w[24:20];
        case (w[6:0])
            OPC_OP: begin
                d.format = FMT_R;
                case (f3)
                    F3_0: begin
                        bad = !f7_ok(f7);
                        d.operation = (f7 == F7_ALT) ? OP_SUB : OP_ADD;
                    end
                    F3_1: d.operation = OP_SLL;
                    F3_2: d.operation = OP_SLT;
                    F3_3: d.operation = OP_SLTU;
                    F3_4: d.operation = OP_XOR;
                    F3_5: begin
                        bad = !f7_ok(f7);
                        d.operation = (f7 == F7_ALT) ? OP_SRA : OP_SRL;
                    end
                    F3_6: d.operation = OP_OR;
                    default: d.operation = OP_AND;
                endcase
            end
            OPC_OP_IMM: begin
                d.format    = FMT_I;
                d.immediate = imm_i;
                case (f3)
                    F3_0: d.operation = OP_ADDI;
                    F3_1: begin
                        d.operation    = OP_SLLI;
                        d.shift_amount = w[24:20];
                    end
                    F3_2: d.operation = OP_SLTI;
                    F3_3: d.operation = OP_SLTIU;
                    F3_4: d.operation = OP_XORI;
                    F3_5: begin
                        bad = !f7_ok(f7);
                        d.operation    = (f7 == F7_ALT) ? OP_SRAI : OP_SRLI;
                        d.shift_amount = w[24:20];
                    end
                    F3_6: d.operation = OP_ORI;
                    default: d.operation = OP_ANDI;
                endcase
            end
            OPC_STORE: begin
                d.format    = FMT_S;
                d.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
                case (f3)
                    F3_0: d.operation = OP_SB;
                    F3_1: d.operation = OP_SH;
                    F3_2: d.operation = OP_SW;
                    default: bad = 1'b1;
                endcase
            end
            OPC_LOAD: begin
                d.format    = FMT_I;
                d.immediate = imm_i;
                case (f3)
                    F3_0: d.operation = OP_LB;
                    F3_1: d.operation = OP_LH;
                    F3_2: d.operation = OP_LW;
                    F3_4: d.operation = OP_LBU;
                    F3_5: d.operation = OP_LHU;
                    default: bad = 1'b1;
                endcase
            end
            OPC_BRANCH: begin
                d.format    = FMT_B;
                d.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                case (f3)
                    F3_0: d.operation = OP_BEQ;
                    F3_1: d.operation = OP_BNE;
                    F3_4: d.operation = OP_BLT;
                    F3_5: d.operation = OP_BGE;
                    F3_6: d.operation = OP_BLTU;
                    F3_7: d.operation = OP_BGEU;
                    default: bad = 1'b1;
                endcase
            end
            OPC_JALR: begin
                d.format    = FMT_I;
                d.immediate = imm_i;
                d.operation = OP_JALR;
                bad = (f3 != F3_0);
            end
            OPC_JAL: begin
                d.format    = FMT_J;
                d.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
                d.operation = OP_JAL;
            end
            OPC_AUIPC: begin
                d.format    = FMT_U;
                d.immediate = {w[31:12], 12'd0};
                d.operation = OP_AUIPC;
            end
            OPC_LUI: begin
                d.format    = FMT_U;
                d.immediate = {w[31:12], 12'd0};
                d.operation = OP_LUI;
            end
            default: bad = 1'b1;
        endcase
        if (d.format == FMT_S || d.format == FMT_B)
            d.dest_reg = '0;
        if (d.format == FMT_U || d.format == FMT_J)
            d.src1_reg = '0;
        if (d.format == FMT_I || d.format == FMT_U || d.format == FMT_J)
            d.src2_reg = '0;
        if (bad) begin
            d = '0;
            d.illegal = 1'b1;
        end
        return d;
    endfunction

    task automatic add_row(input logic [WORD_W-1:0] w, input bit typed, input t_dec want);
        t_row r;
        r.word  = w;
        r.typed = typed;
        r.want  = want;
        rows.push_back(r);
    endtask

    // Drive one word from the falling edge, hold until taken, record its decode.
    task automatic send_word(input logic [WORD_W-1:0] w, input bit typed, input t_dec want);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            start = 1'b0;
            i_instr_word = $urandom;
            repeat (gap) @(negedge i_clk);
        end
        start = 1'b1;
        i_instr_word = w;
        do @(posedge i_clk); while (busy !== 1'b0);
        decoded_q.push_back(typed ? want : decode_word(w));
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_dec want;
        if ((start && busy === 1'b0) || o_done === 1'b1)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (i_rst_n && o_done === 1'b1) begin
            words_decoded++;
            if (decoded_q.size() == 0) begin
                errors++;
                $display("%0t: result with no word outstanding, expected none, actual op %0d",
                         $time, o_operation);
            end else begin
                want = decoded_q.pop_front();
                if (want.illegal)
                    illegal_count++;
                else if (want.operation < N_OPS)
                    op_seen[want.operation] = 1'b1;
                check_field("illegal",      32'(want.illegal),      32'(o_illegal));
                check_field("operation",    32'(want.operation),    32'(o_operation));
                check_field("format",       32'(want.format),       32'(o_format));
                check_field("dest_reg",     32'(want.dest_reg),     32'(o_dest_reg));
                check_field("src1_reg",     32'(want.src1_reg),     32'(o_src1_reg));
                check_field("src2_reg",     32'(want.src2_reg),     32'(o_src2_reg));
                check_field("shift_amount", 32'(want.shift_amount), 32'(o_shift_amount));
                check_field("immediate",    want.immediate,         o_immediate);
            end
        end
    end

    initial begin
        stall_cycles = 0;
        #1;
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin
        t_dec        bad_dec;
        t_dec        lui_max;
        t_dec        none;
        logic [31:0] w;
        logic [6:0]  opc;
        int          pick;
        int          ops_hit;

        errors        = 0;
        words_decoded = 0;
        illegal_count = 0;
        gaps_on       = 1'b1;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_instr_word  = '0;

        none    = '0;
        bad_dec = '0;
        bad_dec.illegal = 1'b1;
        lui_max = '0;
        lui_max.operation = OP_LUI;
        lui_max.format    = FMT_U;
        lui_max.dest_reg  = 5'd31;
        lui_max.immediate = 32'hFFFF_F000;

        add_row(32'h0000_0000, 1'b1, bad_dec);
        add_row(32'hFFFF_FFFF, 1'b1, bad_dec);
        add_row({F7_BASE, 5'd31, 5'd1, F3_0, 5'd31, OPC_OP}, 1'b0, none);
        add_row({F7_ALT, 5'd0, 5'd31, F3_0, 5'd0, OPC_OP}, 1'b0, none);
        add_row({7'd1, 5'd3, 5'd4, F3_0, 5'd5, OPC_OP}, 1'b1, bad_dec);
        add_row({F7_ALT, 5'd7, 5'd8, F3_5, 5'd9, OPC_OP}, 1'b0, none);
        add_row({7'h7F, 5'd10, 5'd11, F3_7, 5'd12, OPC_OP}, 1'b0, none);
        add_row({7'h7F, 5'd31, 5'd31, F3_1, 5'd31, OPC_OP_IMM}, 1'b0, none);
        add_row({F7_ALT, 5'd31, 5'd2, F3_5, 5'd3, OPC_OP_IMM}, 1'b0, none);
        add_row({7'd64, 5'd4, 5'd5, F3_5, 5'd6, OPC_OP_IMM}, 1'b1, bad_dec);
        add_row({12'h800, 5'd1, F3_0, 5'd2, OPC_OP_IMM}, 1'b0, none);
        add_row({12'h7FF, 5'd31, F3_6, 5'd0, OPC_OP_IMM}, 1'b0, none);
        add_row({7'h7F, 5'd31, 5'd31, F3_2, 5'd31, OPC_STORE}, 1'b0, none);
        add_row({7'h00, 5'd1, 5'd2, F3_3, 5'd0, OPC_STORE}, 1'b1, bad_dec);
        add_row({12'hFFF, 5'd31, F3_5, 5'd31, OPC_LOAD}, 1'b0, none);
        add_row({12'h000, 5'd1, F3_7, 5'd1, OPC_LOAD}, 1'b1, bad_dec);
        add_row({7'h7F, 5'd31, 5'd31, F3_7, 5'd31, OPC_BRANCH}, 1'b0, none);
        add_row({7'h00, 5'd0, 5'd0, F3_0, 5'd0, OPC_BRANCH}, 1'b0, none);
        add_row({7'h3F, 5'd5, 5'd6, F3_2, 5'd1, OPC_BRANCH}, 1'b1, bad_dec);
        add_row({12'h800, 5'd31, F3_0, 5'd1, OPC_JALR}, 1'b0, none);
        add_row({12'h001, 5'd2, F3_1, 5'd3, OPC_JALR}, 1'b1, bad_dec);
        add_row({20'hFFFFF, 5'd31, OPC_JAL}, 1'b0, none);
        add_row({20'h80000, 5'd0, OPC_JAL}, 1'b0, none);
        add_row({20'h00001, 5'd0, OPC_AUIPC}, 1'b0, none);
        add_row({20'hFFFFF, 5'd31, OPC_LUI}, 1'b1, lui_max);

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (rows[k])
            send_word(rows[k].word, rows[k].typed, rows[k].want);

        // Mostly well-formed words with random content; the rest is raw noise.
        for (int n = 0; n < N_RANDOM; n++) begin
            gaps_on = (n < N_RANDOM - N_STEADY);
            w = $urandom;
            if ($urandom_range(0, 99) >= 15) begin
                opc = VALID_OPC[4'($urandom_range(0, 8))];
                w[6:0] = opc;
                pick = $urandom_range(0, 9);
                if ((opc == OPC_OP || (opc == OPC_OP_IMM && $urandom_range(0, 1) == 1))
                    && pick < 8)
                    w[31:25] = (pick < 4) ? F7_BASE : F7_ALT;
            end
            send_word(w, 1'b0, none);
        end
        start = 1'b0;

        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        ops_hit = 0;
        foreach (op_seen[k])
            ops_hit += int'(op_seen[k]);
        $display("Decoded %0d words (%0d directed, %0d random), %0d flagged illegal.",
                 words_decoded, rows.size(), N_RANDOM, illegal_count);
        $display("%0d of %0d operations decoded; input gaps off for the last %0d words.",
                 ops_hit, N_OPS, N_STEADY);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### rv32i_instruction_decoder_unit.f
rtl/core/rvid_pkg.sv
rtl/core/rvid_decode.sv
rtl/core/rv32i_instruction_decoder_unit.sv
rtl/core/rvid_checker.sv
tb/tb_top.sv
